### hw/rtl/assert_macros.svh
// Assertion helpers for the checker of this block.
// Each expects clk_i and rst_ni in the scope of its use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/bole_pkg.sv
`default_nettype none

package bole_pkg;

  localparam int unsigned DEPTH = 32;
  localparam int unsigned IdxW  = $clog2(DEPTH);
  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned SumW  = IdxW + 1;

  localparam logic [CntW-1:0] CountFull = CntW'(DEPTH);

  typedef enum logic [2:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_CONTAINS   = 3'd3,
    FN_REMOVE_ALL = 3'd4,
    FN_DUMP       = 3'd5
  } bole_func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } bole_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_OP,
    S_POP,
    S_WALK
  } bole_state_e;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] element_value;
  } bole_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic signed [31:0] data_value;
    logic [5:0]         entry_total;
    logic               last;
  } bole_res_t;

  // Physical slot of a list position: head plus offset, wrapped once.
  function automatic logic [IdxW-1:0] bole_slot(input logic [IdxW-1:0] head,
                                                input logic [IdxW-1:0] off);
    logic [SumW-1:0] s;
    s = {1'b0, head} + {1'b0, off};
    if (s >= SumW'(DEPTH)) begin
      s = s - SumW'(DEPTH);
    end
    return s[IdxW-1:0];
  endfunction

  // Slot in front of the head, wrapping below zero.
  function automatic logic [IdxW-1:0] bole_dec(input logic [IdxW-1:0] head);
    logic [IdxW-1:0] r;
    if (head == '0) begin
      r = IdxW'(DEPTH - 1);
    end else begin
      r = head - IdxW'(1);
    end
    return r;
  endfunction

  // Element count as reported on the result port.
  function automatic logic [5:0] bole_total(input logic [CntW-1:0] c);
    logic [CntW+5:0] w;
    w = {6'b0, c};
    return w[5:0];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/bole_ram.sv
`default_nettype none

module bole_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/bounded_ordered_list_engine_unit.sv
`default_nettype none
// Ordered list of up to DEPTH signed 32-bit values kept in a circular store.
// Request channel: start_i with req_i (func, element_value) is transferred at
// a rising edge where busy_o is low. busy_o rises on the next cycle and stays
// high until the request has issued its last result.
// Result channel: res_valid_o marks each result for exactly one cycle; the
// receiver cannot stall, so every result is taken when shown.
// Each request but a dump of a non-empty list returns one result with last
// set; such a dump returns one result per element, front to back, in
// consecutive cycles, last on the final. Push and unused codes register their
// result in S_OP; a non-empty pop reads the store in S_OP and answers in S_POP.
// Contains, remove-all and dump walk the n stored elements in S_WALK with one
// store read per cycle, overlapped with the compare and write-back of the
// element before; on an empty list they answer in S_OP. The store has a single
// read port. Remove-all compacts in place, writing kept elements behind the
// read pointer, so the walk needs no interlock.
// Reset clears head, count and control; the store itself is not cleared
// since only live entries are ever read.
module bounded_ordered_list_engine_unit import bole_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  wire bole_req_t req_i,
  output logic           busy_o,
  output logic           res_valid_o,
  output bole_res_t      res_o
);

  bole_state_e     state_q, state_d;
  bole_req_t       req_q, req_d;
  logic [IdxW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] rd_cnt_q, rd_cnt_d;
  logic [CntW-1:0] pr_idx_q, pr_idx_d;
  logic [CntW-1:0] kept_q, kept_d;
  logic            pend_q, pend_d;
  logic            hit_q, hit_d;
  bole_res_t       res_q, res_d;
  logic            res_valid_q, res_valid_d;

  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  logic [31:0]     ram_wdata;
  logic            ram_re;
  logic [IdxW-1:0] ram_raddr;
  logic [31:0]     ram_rdata;

  logic            match;
  logic            is_last;

  bole_ram #(
    .Width(32),
    .Depth(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign match   = (ram_rdata == req_q.element_value);
  assign is_last = ((pr_idx_q + CntW'(1)) == count_q);

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    head_d      = head_q;
    count_d     = count_q;
    rd_cnt_d    = rd_cnt_q;
    pr_idx_d    = pr_idx_q;
    kept_d      = kept_q;
    pend_d      = 1'b0;
    hit_d       = hit_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = head_q;
    ram_wdata   = req_q.element_value;
    ram_re      = 1'b0;
    ram_raddr   = head_q;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          req_d   = req_i;
          state_d = S_OP;
        end
      end

      S_OP: begin
        // Default result: ok, nothing found, no data, last.
        res_d.status     = ST_OK;
        res_d.found      = 1'b0;
        res_d.data_value = '0;
        res_d.last       = 1'b1;
        state_d          = S_IDLE;
        unique case (req_q.func)
          FN_PUSH_FRONT, FN_PUSH_BACK: begin
            res_valid_d = 1'b1;
            if (count_q == CountFull) begin
              res_d.status = ST_FULL;
            end else begin
              ram_we  = 1'b1;
              count_d = count_q + CntW'(1);
              if (req_q.func == FN_PUSH_FRONT) begin
                head_d    = bole_dec(head_q);
                ram_waddr = bole_dec(head_q);
              end else begin
                ram_waddr = bole_slot(head_q, count_q[IdxW-1:0]);
              end
            end
          end
          FN_POP_FRONT: begin
            if (count_q == '0) begin
              res_valid_d  = 1'b1;
              res_d.status = ST_EMPTY;
            end else begin
              ram_re  = 1'b1;
              state_d = S_POP;
            end
          end
          FN_CONTAINS, FN_REMOVE_ALL, FN_DUMP: begin
            if (count_q == '0) begin
              res_valid_d = 1'b1;
              if (req_q.func == FN_DUMP) begin
                res_d.status = ST_EMPTY;
              end
            end else begin
              rd_cnt_d = '0;
              hit_d    = 1'b0;
              kept_d   = '0;
              state_d  = S_WALK;
            end
          end
          default: begin
            res_valid_d = 1'b1;
          end
        endcase
      end

      S_POP: begin
        res_valid_d      = 1'b1;
        res_d.data_value = ram_rdata;
        head_d           = bole_slot(head_q, IdxW'(1));
        count_d          = count_q - CntW'(1);
        state_d          = S_IDLE;
      end

      S_WALK: begin
        // Issue the next read while the previous element is processed.
        if (rd_cnt_q < count_q) begin
          ram_re    = 1'b1;
          ram_raddr = bole_slot(head_q, rd_cnt_q[IdxW-1:0]);
          rd_cnt_d  = rd_cnt_q + CntW'(1);
          pr_idx_d  = rd_cnt_q;
          pend_d    = 1'b1;
        end
        if (pend_q) begin
          unique case (req_q.func)
            FN_CONTAINS: begin
              hit_d = hit_q | match;
              if (is_last) begin
                res_valid_d = 1'b1;
                res_d.found = hit_d;
              end
            end
            FN_REMOVE_ALL: begin
              // Move each kept element down to the next compacted slot.
              if (!match) begin
                ram_we    = 1'b1;
                ram_waddr = bole_slot(head_q, kept_q[IdxW-1:0]);
                ram_wdata = ram_rdata;
                kept_d    = kept_q + CntW'(1);
              end
              if (is_last) begin
                res_valid_d = 1'b1;
                res_d.found = (kept_d != count_q);
                count_d     = kept_d;
              end
            end
            default: begin
              res_valid_d      = 1'b1;
              res_d.data_value = ram_rdata;
              res_d.last       = is_last;
            end
          endcase
          if (is_last) begin
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_d.entry_total = bole_total(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      rd_cnt_q    <= '0;
      pr_idx_q    <= '0;
      kept_q      <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      rd_cnt_q    <= rd_cnt_d;
      pr_idx_q    <= pr_idx_d;
      kept_q      <= kept_d;
      pend_q      <= pend_d;
      hit_q       <= hit_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers: hold request and result without reset.
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

### hw/rtl/bole_chk.sv
`default_nettype none
`include "assert_macros.svh"

module bole_chk import bole_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      start_i,
  input wire logic      busy_o,
  input wire logic      res_valid_o,
  input wire bole_res_t res_o
);

  // A transfer always raises busy in the cycle after it.
  `ASSERT_NEXT(a_busy_after_start, start_i && !busy_o, busy_o, "busy missing after transfer")

  // Dump results stream without gaps until the last one.
  `ASSERT_NEXT(a_dump_burst, res_valid_o && !res_o.last, res_valid_o, "gap in dump results")

  // A full-store push reports the full count.
  `ASSERT_IMPLIES(a_full_total, res_valid_o && (res_o.status == ST_FULL),
                  res_o.entry_total == bole_total(CountFull), "full status with wrong count")

  // An empty status means no elements and no data.
  `ASSERT_IMPLIES(a_empty_total, res_valid_o && (res_o.status == ST_EMPTY),
                  (res_o.entry_total == 6'd0) && (res_o.data_value == 32'sd0),
                  "empty status with data or count")

  // A hit comes only from a search or removal that succeeded.
  `ASSERT_IMPLIES(a_found_ok, res_valid_o && res_o.found,
                  (res_o.status == ST_OK) && (res_o.data_value == 32'sd0) && res_o.last,
                  "found flag on a non-search result")

endmodule

bind bounded_ordered_list_engine_unit bole_chk u_bole_chk (.*);

`default_nettype wire

### verif/tb_bounded_ordered_list_engine_unit.sv
`timescale 1ns / 100ps

module tb_bounded_ordered_list_engine_unit;
  import bole_pkg::*;

  // Codes the block must ignore: one result, status ok, count unchanged.
  localparam logic [2:0] FuncUnusedLo = 3'd6;
  localparam logic [2:0] FuncUnusedHi = 3'd7;

  localparam int unsigned ItemTarget   = 500;
  localparam int unsigned TailCycles   = 60;
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned PrintLimit   = 40;

  typedef enum int unsigned {
    SEG_FILL,
    SEG_DRAIN,
    SEG_MIX,
    SEG_SEARCH
  } seg_kind_e;

  // One directed row: the request, plus an expected result where it is
  // obvious by inspection. Other rows are predicted.
  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] value;
    logic               typed;
    bole_res_t          res;
  } dir_row_t;

  localparam int unsigned NumDirRows = 22;

  localparam dir_row_t DirRows [NumDirRows] = '{
    // empty list: pop, dump, contains, remove-all and an unused code
    '{FN_POP_FRONT,  32'sd0,            1'b1, '{ST_EMPTY, 1'b0, 32'sd0, 6'd0, 1'b1}},
    '{FN_DUMP,       32'sd0,            1'b1, '{ST_EMPTY, 1'b0, 32'sd0, 6'd0, 1'b1}},
    '{FN_CONTAINS,   32'sd0,            1'b1, '{ST_OK,    1'b0, 32'sd0, 6'd0, 1'b1}},
    '{FN_REMOVE_ALL, 32'sd0,            1'b1, '{ST_OK,    1'b0, 32'sd0, 6'd0, 1'b1}},
    '{FuncUnusedLo,  -32'sd1,           1'b1, '{ST_OK,    1'b0, 32'sd0, 6'd0, 1'b1}},
    // value extremes at both ends
    '{FN_PUSH_BACK,  32'sh7FFF_FFFF,    1'b1, '{ST_OK,    1'b0, 32'sd0, 6'd1, 1'b1}},
    '{FN_PUSH_FRONT, 32'sh8000_0000,    1'b1, '{ST_OK,    1'b0, 32'sd0, 6'd2, 1'b1}},
    '{FuncUnusedHi,  32'sd0,            1'b1, '{ST_OK,    1'b0, 32'sd0, 6'd2, 1'b1}},
    '{FN_PUSH_BACK,  -32'sd1,           1'b0, '0},
    '{FN_PUSH_BACK,  32'sd0,            1'b0, '0},
    '{FN_PUSH_FRONT, -32'sd1,           1'b0, '0},
    // membership must see the tail element too
    '{FN_CONTAINS,   32'sd0,            1'b0, '0},
    '{FN_CONTAINS,   32'sh8000_0000,    1'b0, '0},
    '{FN_CONTAINS,   32'sd1,            1'b0, '0},
    '{FN_DUMP,       32'sd0,            1'b0, '0},
    // remove both copies, then find none left
    '{FN_REMOVE_ALL, -32'sd1,           1'b0, '0},
    '{FN_REMOVE_ALL, -32'sd1,           1'b0, '0},
    '{FN_DUMP,       32'sh5A5A_A5A5,    1'b0, '0},
    '{FN_POP_FRONT,  32'sh1234_5678,    1'b0, '0},
    '{FN_POP_FRONT,  32'sd0,            1'b0, '0},
    '{FN_POP_FRONT,  32'sd0,            1'b0, '0},
    '{FN_POP_FRONT,  -32'sd1,           1'b1, '{ST_EMPTY, 1'b0, 32'sd0, 6'd0, 1'b1}}
  };

  logic      clk_i;
  logic      rst_ni;
  logic      start_i;
  bole_req_t req_i;
  logic      busy_o;
  logic      res_valid_o;
  bole_res_t res_o;

  // Predicted contents, front at index 0, and results still to arrive.
  logic signed [31:0] list_model [$];
  bole_res_t          pending_results [$];

  int unsigned error_count;
  int unsigned result_count;
  int unsigned items_sent;
  int unsigned idle_cycles;
  bit          sender_idles;

  bounded_ordered_list_engine_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_i      (req_i),
    .busy_o     (busy_o),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bole_res_t make_result(input logic [1:0] status, input logic found,
                                            input logic signed [31:0] data,
                                            input logic last);
    bole_res_t r;
    r.status      = status;
    r.found       = found;
    r.data_value  = data;
    r.entry_total = 6'(list_model.size());
    r.last        = last;
    return r;
  endfunction

  // Apply one transferred request to the list and queue the results it owes.
  function automatic void apply_list_request(input bole_req_t req);
    logic signed [31:0] kept [$];
    logic signed [31:0] head_val;
    logic               hit;
    int unsigned        n;
    hit = 1'b0;
    n   = list_model.size();
    case (req.func)
      FN_PUSH_FRONT, FN_PUSH_BACK: begin
        if (n >= DEPTH) begin
          pending_results.push_back(make_result(ST_FULL, 1'b0, 32'sd0, 1'b1));
        end else begin
          if (req.func == FN_PUSH_FRONT) list_model.push_front(req.element_value);
          else list_model.push_back(req.element_value);
          pending_results.push_back(make_result(ST_OK, 1'b0, 32'sd0, 1'b1));
        end
      end
      FN_POP_FRONT: begin
        if (n == 0) begin
          pending_results.push_back(make_result(ST_EMPTY, 1'b0, 32'sd0, 1'b1));
        end else begin
          head_val = list_model.pop_front();
          pending_results.push_back(make_result(ST_OK, 1'b0, head_val, 1'b1));
        end
      end
      FN_CONTAINS: begin
        foreach (list_model[i]) if (list_model[i] == req.element_value) hit = 1'b1;
        pending_results.push_back(make_result(ST_OK, hit, 32'sd0, 1'b1));
      end
      FN_REMOVE_ALL: begin
        // keep order of the survivors
        foreach (list_model[i]) begin
          if (list_model[i] != req.element_value) kept.push_back(list_model[i]);
        end
        hit        = (kept.size() < n);
        list_model = kept;
        pending_results.push_back(make_result(ST_OK, hit, 32'sd0, 1'b1));
      end
      FN_DUMP: begin
        if (n == 0) begin
          pending_results.push_back(make_result(ST_EMPTY, 1'b0, 32'sd0, 1'b1));
        end else begin
          foreach (list_model[i]) begin
            pending_results.push_back(make_result(ST_OK, 1'b0, list_model[i], i == n - 1));
          end
        end
      end
      default: begin
        pending_results.push_back(make_result(ST_OK, 1'b0, 32'sd0, 1'b1));
      end
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!sender_idles || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mix fresh random words, values already stored, and a few corner values
  // so that searches and removals hit as well as miss.
  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] corners [5];
    int unsigned        r;
    corners = '{-32'sd1, 32'sd0, 32'sd1, 32'sh8000_0000, 32'sh7FFF_FFFF};
    r = $urandom_range(0, 3);
    if (r == 2 && list_model.size() != 0) begin
      return list_model[$urandom_range(0, list_model.size() - 1)];
    end
    if (r == 3) return corners[$urandom_range(0, 4)];
    return $urandom;
  endfunction

  function automatic logic [2:0] pick_func(input seg_kind_e kind);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (kind == SEG_SEARCH) begin
      if (r < 15) return FN_PUSH_FRONT;
      if (r < 30) return FN_PUSH_BACK;
      if (r < 35) return FN_POP_FRONT;
      if (r < 60) return FN_CONTAINS;
      if (r < 75) return FN_REMOVE_ALL;
      if (r < 98) return FN_DUMP;
    end else begin
      if (r < 22) return FN_PUSH_FRONT;
      if (r < 44) return FN_PUSH_BACK;
      if (r < 62) return FN_POP_FRONT;
      if (r < 76) return FN_CONTAINS;
      if (r < 86) return FN_REMOVE_ALL;
      if (r < 97) return FN_DUMP;
    end
    return $urandom_range(0, 1) ? FuncUnusedLo : FuncUnusedHi;
  endfunction

  // Present one request after an optional idle gap, hold it until busy_o is low at
  // an edge, then predict its results at that edge.
  task automatic transfer_request(input logic [2:0] func, input logic signed [31:0] value);
    bole_req_t   req;
    int unsigned gap;
    req.func          = func;
    req.element_value = value;
    gap               = pick_gap();
    if (gap != 0) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    req_i   <= req;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    apply_list_request(req);
    items_sent++;
  endtask

  task automatic send_random(input seg_kind_e kind);
    transfer_request(pick_func(kind), pick_value());
  endtask

  // Drop start first so the last request is not taken a second time.
  task automatic wait_results_drained();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    error_count++;
    if (error_count <= PrintLimit) begin
      $display("%0t: result %0d %s: want %h got %h", $realtime, result_count, what, want, got);
    end
  endtask

  // Results cannot be held off, so take every one that is shown.
  always @(posedge clk_i) begin
    bole_res_t want;
    if (rst_ni && res_valid_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result", '0, res_o.data_value);
      end else begin
        want = pending_results.pop_front();
        if (res_o.status !== want.status) begin
          flag_mismatch("status", 32'(want.status), 32'(res_o.status));
        end
        if (res_o.found !== want.found) begin
          flag_mismatch("found", 32'(want.found), 32'(res_o.found));
        end
        if (res_o.data_value !== want.data_value) begin
          flag_mismatch("data_value", want.data_value, res_o.data_value);
        end
        if (res_o.entry_total !== want.entry_total) begin
          flag_mismatch("entry_total", 32'(want.entry_total), 32'(res_o.entry_total));
        end
        if (res_o.last !== want.last) begin
          flag_mismatch("last", 32'(want.last), 32'(res_o.last));
        end
      end
      result_count++;
    end
  end

  // Abort if neither a request nor a result moves for too long.
  always @(posedge clk_i) begin
    if ((rst_ni && start_i && busy_o === 1'b0) || res_valid_o === 1'b1) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("tb_bounded_ordered_list_engine_unit: errors");
      $finish;
    end
  end

  initial begin
    seg_kind_e   kind;
    int unsigned seg_index;
    int unsigned seg_len;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    req_i        = '0;
    items_sent   = 0;
    sender_idles = 1'b1;
    seg_index    = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: a typed row replaces the prediction it stands for.
    for (int unsigned i = 0; i < NumDirRows; i++) begin
      transfer_request(DirRows[i].func, DirRows[i].value);
      if (DirRows[i].typed) pending_results[pending_results.size() - 1] = DirRows[i].res;
    end

    // Random part in segments; the early ones force a fill and a drain.
    while (items_sent < ItemTarget) begin
      case (seg_index)
        1:       kind = SEG_FILL;
        3:       kind = SEG_DRAIN;
        default: kind = seg_kind_e'($urandom_range(0, 3));
      endcase
      sender_idles = ($urandom_range(0, 3) != 0);
      // hold off until the block has returned everything at least once
      if (seg_index == 2 || $urandom_range(0, 4) == 0) wait_results_drained();
      case (kind)
        SEG_FILL: begin
          while (list_model.size() < DEPTH) begin
            transfer_request($urandom_range(0, 1) ? FN_PUSH_FRONT : FN_PUSH_BACK,
                             pick_value());
          end
          repeat (2) begin
            transfer_request($urandom_range(0, 1) ? FN_PUSH_FRONT : FN_PUSH_BACK,
                             pick_value());
          end
          transfer_request(FN_DUMP, pick_value());
          transfer_request(FN_CONTAINS, list_model[DEPTH - 1]);
          transfer_request(FN_REMOVE_ALL, pick_value());
        end
        SEG_DRAIN: begin
          while (list_model.size() != 0) transfer_request(FN_POP_FRONT, pick_value());
          transfer_request(FN_POP_FRONT, pick_value());
          transfer_request(FN_DUMP, pick_value());
        end
        default: begin
          seg_len = $urandom_range(25, 50);
          repeat (seg_len) send_random(kind);
        end
      endcase
      seg_index++;
    end

    @(negedge clk_i);
    start_i <= 1'b0;
    wait_results_drained();
    // let any stray result show up before the verdict
    repeat (TailCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_bounded_ordered_list_engine_unit: clean");
    end else begin
      $display("tb_bounded_ordered_list_engine_unit: errors");
    end
    $finish;
  end

endmodule

### bounded_ordered_list_engine_unit.f
+incdir+hw/rtl
hw/rtl/bole_pkg.sv
hw/rtl/bole_ram.sv
hw/rtl/bounded_ordered_list_engine_unit.sv
hw/rtl/bole_chk.sv
verif/tb_bounded_ordered_list_engine_unit.sv
